// ===== design/range_add_range_max_tree_unit_macros.svh =====
// assertion helpers shared by the checker
`ifndef RANGE_ADD_RANGE_MAX_TREE_UNIT_MACROS_SVH
`define RANGE_ADD_RANGE_MAX_TREE_UNIT_MACROS_SVH

// same-cycle implication
`define RARM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rarm check failed");

// next-cycle implication
`define RARM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rarm check failed");

`endif

// ===== design/rarm_pkg.sv =====
package rarm_pkg;
  localparam int VAL_W   = 56;
  localparam int POS_W   = 11;
  localparam int DELTA_W = 48;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic {
    ALU_SAT_ADD,
    ALU_MAX
  } alu_op_t;
endpackage

// ===== design/range_add_range_max_tree_unit.sv =====
// an add or query walks the tree node by node (node memory with one read port and
// one write port, one saturating add or compare per cycle)
// an empty range does not walk the tree: an add is dropped, a query gives a zero result beat
// reset and every leaf_count write start a clearing pass that zeroes all 2*LEAVES
// node words, no item is taken during it; leaf_count resets to 1024
module range_add_range_max_tree_unit import rarm_pkg::*; #(
  parameter int LEAVES = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [POS_W-1:0]          in_range_low,
  input  logic [POS_W-1:0]          in_range_high,
  input  logic signed [DELTA_W-1:0] in_delta,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VAL_W-1:0]   out_max_value,
  input  logic                      cfg_wr_en,
  input  logic [POS_W-1:0]          cfg_wr_data
);
  localparam int NODES = 2 * LEAVES;
  localparam int AW    = $clog2(NODES);
  localparam int SD    = $clog2(LEAVES) + 1;
  localparam int IW    = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_ENTER = 5'd2;
  localparam logic [4:0] S_NODE  = 5'd3;
  localparam logic [4:0] S_APPLY = 5'd4;
  localparam logic [4:0] S_PL1   = 5'd5;
  localparam logic [4:0] S_PL2   = 5'd6;
  localparam logic [4:0] S_PR1   = 5'd7;
  localparam logic [4:0] S_PR2   = 5'd8;
  localparam logic [4:0] S_PX    = 5'd9;
  localparam logic [4:0] S_DESC  = 5'd10;
  localparam logic [4:0] S_RET   = 5'd11;
  localparam logic [4:0] S_RES   = 5'd12;
  localparam logic [4:0] S_FIX   = 5'd13;
  localparam logic [4:0] S_FIX1  = 5'd14;
  localparam logic [4:0] S_FIX2  = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  typedef struct packed {
    logic [AW-1:0] x;
    pos_t          l;
    pos_t          r;
    logic          ph;
    val_t          a;
  } frame_t;

  logic [4:0]     state_r, state_nxt;
  pos_t           leaf_count_r, leaf_count_nxt;
  logic           kind_r, kind_nxt;
  pos_t           lo_r, lo_nxt, hi_r, hi_nxt;
  val_t           v_r, v_nxt;
  frame_t         cur_r, cur_nxt;
  val_t           ret_r, ret_nxt, tmp_r, tmp_nxt, t_r, t_nxt;
  val_t           mx_r, mx_nxt, ctag_r, ctag_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;
  frame_t         stk_r [SD];

  logic           stk_we;
  frame_t         stk_wd;
  logic [SPW-1:0] sp_m1;
  frame_t         top_frame;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [2*VAL_W-1:0] ram_wdata, ram_rdata;
  val_t               rd_max, rd_tag;

  alu_op_t alu_op;
  val_t    alu_a, alu_b, alu_y;

  pos_t          n_span, mid, lo_c, hi_c;
  logic [AW-1:0] lc, rc;
  logic          covered, go_left, go_right;
  frame_t        left_f, right_f;

  rarm_ram #(.W(2 * VAL_W), .DEPTH(NODES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rarm_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign rd_max    = ram_rdata[2*VAL_W-1:VAL_W];
  assign rd_tag    = ram_rdata[VAL_W-1:0];
  assign sp_m1     = sp_r - 1'b1;
  assign top_frame = stk_r[sp_m1[IW-1:0]];

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = (state_r == S_OUT);
  assign out_max_value = ret_r;

  always_comb begin
    if (leaf_count_r == '0) begin
      n_span = POS_W'(1);
    end else if (32'(leaf_count_r) > LEAVES) begin
      n_span = POS_W'(LEAVES);
    end else begin
      n_span = leaf_count_r;
    end
    lo_c = (in_range_low == '0) ? POS_W'(1) : in_range_low;
    hi_c = (in_range_high > n_span) ? n_span : in_range_high;

    mid      = POS_W'(((POS_W+1)'(cur_r.l) + (POS_W+1)'(cur_r.r)) >> 1);
    lc       = cur_r.x + 1'b1;
    rc       = cur_r.x + AW'({POS_W'(mid - cur_r.l + 1'b1), 1'b0});
    covered  = (lo_r <= cur_r.l) && (cur_r.r <= hi_r);
    go_left  = (lo_r <= mid);
    go_right = (hi_r > mid);
    left_f   = '{x: lc, l: cur_r.l, r: mid, ph: 1'b0, a: '0};
    right_f  = '{x: rc, l: POS_W'(mid + 1'b1), r: cur_r.r, ph: 1'b0, a: '0};
  end

  always_comb begin
    state_nxt      = state_r;
    leaf_count_nxt = leaf_count_r;
    kind_nxt       = kind_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    v_nxt          = v_r;
    cur_nxt        = cur_r;
    ret_nxt        = ret_r;
    tmp_nxt        = tmp_r;
    t_nxt          = t_r;
    mx_nxt         = mx_r;
    ctag_nxt       = ctag_r;
    sp_nxt         = sp_r;
    clr_nxt        = clr_r;
    stk_we         = 1'b0;
    stk_wd         = cur_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_r.x;
    ram_wdata      = '0;
    ram_raddr      = cur_r.x;
    alu_op         = ALU_SAT_ADD;
    alu_a          = rd_max;
    alu_b          = t_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          lo_nxt   = lo_c;
          hi_nxt   = hi_c;
          v_nxt    = VAL_W'(in_delta);
          sp_nxt   = '0;
          cur_nxt  = '{x: AW'(1), l: POS_W'(1), r: n_span, ph: 1'b0, a: '0};
          if (lo_c > hi_c) begin
            ret_nxt   = '0;
            state_nxt = in_kind ? S_OUT : S_IDLE;
          end else begin
            state_nxt = S_ENTER;
          end
        end
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_ENTER: state_nxt = S_NODE;
      S_NODE: begin
        if (covered) begin
          if (kind_r) begin
            ret_nxt   = rd_max;
            state_nxt = S_RET;
          end else begin
            alu_b     = v_r;
            tmp_nxt   = alu_y;
            t_nxt     = rd_tag;
            state_nxt = S_APPLY;
          end
        end else if (rd_tag == '0) begin
          state_nxt = S_DESC;
        end else begin
          t_nxt     = rd_tag;
          mx_nxt    = rd_max;
          ram_raddr = lc;
          state_nxt = S_PL1;
        end
      end
      S_APPLY: begin
        alu_a     = t_r;
        alu_b     = v_r;
        ram_we    = 1'b1;
        ram_wdata = {tmp_r, alu_y};
        state_nxt = S_RET;
      end
      S_PL1, S_PR1: begin
        tmp_nxt   = alu_y;
        ctag_nxt  = rd_tag;
        state_nxt = (state_r == S_PL1) ? S_PL2 : S_PR2;
      end
      S_PL2: begin
        alu_a     = ctag_r;
        ram_we    = 1'b1;
        ram_waddr = lc;
        ram_wdata = {tmp_r, alu_y};
        ram_raddr = rc;
        state_nxt = S_PR1;
      end
      S_PR2: begin
        alu_a     = ctag_r;
        ram_we    = 1'b1;
        ram_waddr = rc;
        ram_wdata = {tmp_r, alu_y};
        state_nxt = S_PX;
      end
      S_PX: begin
        ram_we    = 1'b1;
        ram_wdata = {mx_r, {VAL_W{1'b0}}};
        state_nxt = S_DESC;
      end
      S_DESC: begin
        stk_we    = 1'b1;
        stk_wd    = cur_r;
        stk_wd.ph = !go_left;
        sp_nxt    = sp_r + 1'b1;
        cur_nxt   = go_left ? left_f : right_f;
        state_nxt = S_ENTER;
      end
      S_RET: begin
        if (sp_r == '0) begin
          state_nxt = kind_r ? S_OUT : S_IDLE;
        end else begin
          cur_nxt   = top_frame;
          sp_nxt    = sp_m1;
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (!cur_r.ph && go_right) begin
          stk_we    = 1'b1;
          stk_wd    = cur_r;
          stk_wd.ph = 1'b1;
          stk_wd.a  = ret_r;
          sp_nxt    = sp_r + 1'b1;
          cur_nxt   = right_f;
          state_nxt = S_ENTER;
        end else if (kind_r) begin
          if (cur_r.ph && go_left) begin
            alu_op  = ALU_MAX;
            alu_a   = cur_r.a;
            alu_b   = ret_r;
            ret_nxt = alu_y;
          end
          state_nxt = S_RET;
        end else begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        ram_raddr = lc;
        state_nxt = S_FIX1;
      end
      S_FIX1: begin
        tmp_nxt   = rd_max;
        ram_raddr = rc;
        state_nxt = S_FIX2;
      end
      S_FIX2: begin
        alu_op    = ALU_MAX;
        alu_a     = tmp_r;
        alu_b     = rd_max;
        ram_we    = 1'b1;
        ram_wdata = {alu_y, {VAL_W{1'b0}}};
        state_nxt = S_RET;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr_en) begin
      leaf_count_nxt = cfg_wr_data;
      clr_nxt        = '0;
      state_nxt      = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      leaf_count_r <= POS_W'(1024);
      clr_r        <= '0;
      sp_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      leaf_count_r <= leaf_count_nxt;
      clr_r        <= clr_nxt;
      sp_r         <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    v_r    <= v_nxt;
    cur_r  <= cur_nxt;
    ret_r  <= ret_nxt;
    tmp_r  <= tmp_nxt;
    t_r    <= t_nxt;
    mx_r   <= mx_nxt;
    ctag_r <= ctag_nxt;
    if (stk_we) begin
      stk_r[sp_r[IW-1:0]] <= stk_wd;
    end
  end
endmodule

// ===== design/rarm_ram.sv =====
module rarm_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/rarm_alu.sv =====
module rarm_alu import rarm_pkg::*; (
  input  alu_op_t op,
  input  val_t    a,
  input  val_t    b,
  output val_t    y
);
  logic signed [VAL_W:0] sum;

  always_comb begin
    sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    case (op)
      ALU_SAT_ADD: begin
        if (sum[VAL_W] != sum[VAL_W-1]) begin
          y = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
          y = sum[VAL_W-1:0];
        end
      end
      ALU_MAX: y = (a > b) ? a : b;
      default: y = a;
    endcase
  end
endmodule

// ===== design/rarm_checker.sv =====
`include "range_add_range_max_tree_unit_macros.svh"

module rarm_checker import rarm_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      in_kind,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [VAL_W-1:0]   out_max_value,
  input logic                      cfg_wr_en
);
  // a waiting result beat holds
  `RARM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_max_value))
  // one item in flight: no new beat while a result waits
  `RARM_ASSERT_NOW(a_busy_out, clk, rst_n, out_valid, in_stall)
  // a span write starts the clearing pass
  `RARM_ASSERT_NEXT(a_cfg_clear, clk, rst_n, cfg_wr_en, in_stall && !out_valid)
  // an add beat never yields a result beat next
  `RARM_ASSERT_NEXT(a_add_quiet, clk, rst_n, in_valid && !in_stall && !in_kind && !cfg_wr_en, !out_valid)
endmodule

bind range_add_range_max_tree_unit rarm_checker u_rarm_checker (.*);
